@@ src/lfsa_pkg.sv @@
package lfsa_pkg;

  // table geometry
  localparam int SLOTS    = 16;
  localparam int KEY_BITS = 32;

  // transaction field widths
  localparam int IN_KEY_W = 32;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int LEN_W    = $clog2(SLOTS + 1);
  localparam int STATUS_W = 3;

  // request kinds
  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_NEW       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming request
    logic scan;    // read one table entry and step the slot counter
    logic commit;  // apply the update and fill the result register
  } lfsa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_key_null;  // incoming key is the null key
    logic cnt_last;     // slot counter points at the last slot
    logic out_free;     // result register can take a new result
  } lfsa_sts_t;

endpackage

@@ src/lfsa_in_if.sv @@
interface lfsa_in_if;
  import lfsa_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [IN_KEY_W-1:0] key;

  modport source (output valid, output kind, output key, input ready);
  modport sink (input valid, input kind, input key, output ready);
endinterface

@@ src/lfsa_out_if.sv @@
interface lfsa_out_if;
  import lfsa_pkg::*;

  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot;
  logic [STATUS_W-1:0] status;
  logic [LEN_W-1:0]    length;

  modport source (output valid, output slot, output status, output length, input ready);
  modport sink (input valid, input slot, input status, input length, output ready);
endinterface

@@ src/lfsa_ram.sv @@
module lfsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/lfsa_ctrl.sv @@
module lfsa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lfsa_pkg::lfsa_sts_t sts,
  output lfsa_pkg::lfsa_cmd_t cmd
);
  import lfsa_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          // null key needs no table search
          state_nxt = sts.in_key_null ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("commit issued while result register is occupied");

endmodule

@@ src/lfsa_dp.sv @@
module lfsa_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lfsa_pkg::lfsa_cmd_t           cmd,
  output lfsa_pkg::lfsa_sts_t           sts,
  input  logic                          in_kind,
  input  logic [lfsa_pkg::IN_KEY_W-1:0] in_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lfsa_pkg::SLOT_W-1:0]   out_slot,
  output logic [lfsa_pkg::STATUS_W-1:0] out_status,
  output logic [lfsa_pkg::LEN_W-1:0]    out_length
);
  import lfsa_pkg::*;

  function automatic logic [LEN_W-1:0] top_length(input logic [SLOTS-1:0] used);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (used[i]) begin
        n = LEN_W'(i + 1);
      end
    end
    return n;
  endfunction

  // request capture
  logic                kind_r;
  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] in_key_m;

  // scan pipeline
  logic [SLOT_W-1:0]   cnt_r;
  logic                cmp_vld_r;
  logic [SLOT_W-1:0]   cmp_idx_r;
  logic                hit_r;
  logic [SLOT_W-1:0]   hit_idx_r;
  logic [KEY_BITS-1:0] rd_key;
  logic                cmp_hit;

  // table state
  logic [SLOTS-1:0]    used_r;
  logic [SLOTS-1:0]    used_nxt;
  logic [LEN_W-1:0]    len_r;

  // free slot search
  logic                free_found;
  logic [SLOT_W-1:0]   free_idx;

  // commit results
  logic [SLOT_W-1:0]   res_slot;
  logic [STATUS_W-1:0] res_status;
  logic                ram_we;

  // result register
  logic                out_valid_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [STATUS_W-1:0] status_r;
  logic [LEN_W-1:0]    length_r;

  assign in_key_m = KEY_BITS'(in_key);

  lfsa_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(SLOTS)
  ) u_key_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(free_idx),
    .wdata(key_r),
    .raddr(cnt_r),
    .rdata(rd_key)
  );

  // only used slots take part in the compare
  assign cmp_hit = cmp_vld_r && used_r[cmp_idx_r] && (rd_key == key_r) && !hit_r;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    used_nxt   = used_r;
    res_slot   = '0;
    ram_we     = 1'b0;
    res_status = ST_NULL;
    if (key_r == '0) begin
      res_status = ST_NULL;
    end else if (kind_r == KIND_ADD) begin
      if (hit_r) begin
        res_slot   = hit_idx_r;
        res_status = ST_PRESENT;
      end else if (free_found) begin
        res_slot           = free_idx;
        res_status         = ST_NEW;
        used_nxt[free_idx] = 1'b1;
        ram_we             = cmd.commit;
      end else begin
        res_status = ST_FULL;
      end
    end else begin
      if (hit_r) begin
        res_slot            = hit_idx_r;
        res_status          = ST_REMOVED;
        used_nxt[hit_idx_r] = 1'b0;
      end else begin
        res_status = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      key_r  <= in_key_m;
    end
    cmp_idx_r <= cnt_r;
    if (cmp_hit) begin
      hit_idx_r <= cmp_idx_r;
    end
    if (cmd.commit) begin
      slot_r   <= res_slot;
      status_r <= res_status;
      length_r <= top_length(used_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      used_r      <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan;
      if (cmd.load) begin
        cnt_r <= '0;
        hit_r <= 1'b0;
      end else if (cmd.scan) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmp_hit) begin
        hit_r <= 1'b1;
      end
      if (cmd.commit) begin
        used_r <= used_nxt;
        len_r  <= top_length(used_nxt);
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.in_key_null = (in_key_m == '0);
  assign sts.cnt_last    = (cnt_r == SLOT_W'(SLOTS - 1));
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_slot   = slot_r;
  assign out_status = status_r;
  assign out_length = length_r;

  a_new_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && res_status == ST_NEW) |=> used_r[slot_r])
    else $error("new slot not marked used");

  a_remove_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && res_status == ST_REMOVED) |=> !used_r[slot_r])
    else $error("removed slot still marked used");

  a_length_tops_used: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) |-> used_r[SLOT_W'(len_r - 1'b1)])
    else $error("list length does not end on a used slot");

endmodule

@@ src/lowest_free_slot_key_allocator_unit.sv @@
// channel   dir  handshake      payload
// in_ch     in   valid/ready    kind (1), key (32)
// out_ch    out  valid/ready    slot (4), status (3), length (5)
//
// an add or remove transaction passes through acceptance, one full pass over
// the 16 key slots (one key RAM read a cycle), a drain step and a commit step
// before the next one can be taken; a null key goes from acceptance straight
// to the commit step
// rst_n is synchronous; it clears the used bits, the list length and all
// control state; the key RAM is not cleared since entries are only compared
// while their slot is marked used
// the result sits in an output register: a new request is accepted while it
// waits, and the commit of that request stalls until the register is free
module lowest_free_slot_key_allocator_unit (
  input  logic              clk,
  input  logic              rst_n,
  lfsa_in_if.sink           in_ch,
  lfsa_out_if.source        out_ch
);
  import lfsa_pkg::*;

  lfsa_cmd_t cmd;
  lfsa_sts_t sts;

  // sequencer: idle, slot scan, compare drain, commit
  lfsa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // key RAM, used bits, list length, result register
  lfsa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_kind   (in_ch.kind),
    .in_key    (in_ch.key),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_slot  (out_ch.slot),
    .out_status(out_ch.status),
    .out_length(out_ch.length)
  );

endmodule
